[rtl/core/crt_pkg.sv]
// ----------------------------------------------------------------------------
// crt_pkg
// Shared constants, codes and types of the capability rights table.
// ----------------------------------------------------------------------------
package crt_pkg;

	// table geometry
	localparam int CAP_SLOTS  = 64;
	localparam int SLOT_W     = $clog2(CAP_SLOTS);
	localparam int COUNT_W    = $clog2(CAP_SLOTS + 1);
	localparam int INDEX_W    = 8;
	localparam int CMP_W      = (COUNT_W > INDEX_W) ? COUNT_W : INDEX_W;
	localparam int CMD_W      = 3;
	localparam int RIGHTS_W   = 3;
	localparam int STATUS_W   = 3;
	localparam int DATA_W     = 32;
	localparam int NEW_SLOT_W = 6;

	// rights bits: read, write, grant
	localparam logic [RIGHTS_W-1:0] RIGHTS_ALL  = 3'd7;
	localparam logic [RIGHTS_W-1:0] RIGHT_GRANT = 3'd4;

	typedef enum logic [CMD_W-1:0] {
		CMD_CREATE    = 3'd0,
		CMD_GRANT     = 3'd1,
		CMD_REVOKE    = 3'd2,
		CMD_CHECK     = 3'd3,
		CMD_CHECK_ANY = 3'd4
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_FULL      = 3'd1,
		ST_BAD_INDEX = 3'd2,
		ST_INVALID   = 3'd3,
		ST_NO_GRANT  = 3'd4
	} status_t;

	// one stored slot
	typedef struct packed {
		logic signed [DATA_W-1:0] object_ref;
		logic signed [DATA_W-1:0] badge;
		logic [RIGHTS_W-1:0]      rights;
	} crt_entry_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;
		logic lookup;
		logic scan;
		logic commit;
	} crt_ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic need_scan;
		logic scan_done;
		logic out_room;
	} crt_stat_t;

endpackage

[rtl/core/crt_ctrl.sv]
// ----------------------------------------------------------------------------
// crt_ctrl
// Sequencer of the capability rights table: capture, slot lookup, optional
// scan over used slots, then execute and hand the result to the output.
// ----------------------------------------------------------------------------
module crt_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  crt_pkg::crt_stat_t  stat,
	output crt_pkg::crt_ctl_t   ctl
);
	import crt_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_LOOKUP = 4'b0010,
		S_SCAN   = 4'b0100,
		S_EXEC   = 4'b1000
	} state_t;

	state_t state_q, state_d;

	// next state and commands
	always_comb begin
		state_d  = state_q;
		ctl      = '0;
		in_ready = (state_q == S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ctl.capture = 1'b1;
					state_d     = S_LOOKUP;
				end
			end
			S_LOOKUP: begin
				ctl.lookup = 1'b1;
				state_d    = stat.need_scan ? S_SCAN : S_EXEC;
			end
			S_SCAN: begin
				ctl.scan = 1'b1;
				if (stat.scan_done) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				// wait for room in the output register
				if (stat.out_room) begin
					ctl.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[rtl/core/crt_dp.sv]
// ----------------------------------------------------------------------------
// crt_dp
// Datapath of the capability rights table: request registers, slot memory,
// valid bits, fill count, scan counter and the output register.
// ----------------------------------------------------------------------------
module crt_dp (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  crt_pkg::crt_ctl_t                       ctl,
	output crt_pkg::crt_stat_t                      stat,
	input  logic [crt_pkg::CMD_W-1:0]               command,
	input  logic [crt_pkg::INDEX_W-1:0]             slot_index,
	input  logic signed [crt_pkg::DATA_W-1:0]       object_ref,
	input  logic [crt_pkg::RIGHTS_W-1:0]            rights_mask,
	input  logic signed [crt_pkg::DATA_W-1:0]       badge_value,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic [crt_pkg::STATUS_W-1:0]            status,
	output logic [crt_pkg::NEW_SLOT_W-1:0]          new_slot,
	output logic                                    allowed
);
	import crt_pkg::*;

	// request registers
	logic [CMD_W-1:0]         cmd_q;
	logic [INDEX_W-1:0]       index_q;
	logic signed [DATA_W-1:0] obj_q;
	logic [RIGHTS_W-1:0]      mask_q;
	logic signed [DATA_W-1:0] badge_q;

	// table state
	crt_entry_t               slot_mem [CAP_SLOTS];
	logic [CAP_SLOTS-1:0]     slot_valid_q;
	logic [COUNT_W-1:0]       count_q;

	// read port and scan
	crt_entry_t               rd_entry_s1;
	logic                     rd_valid_s1;
	logic                     issued_s1;
	logic [COUNT_W-1:0]       scan_idx_q;
	logic                     hit_q;

	// output register
	logic                     out_valid_q;
	status_t                  out_status_q;
	logic [NEW_SLOT_W-1:0]    out_new_q;
	logic                     out_allowed_q;

	logic                     rd_en;
	logic [SLOT_W-1:0]        rd_addr;
	logic                     scan_left;
	logic                     out_room;
	logic                     in_range;
	logic                     full;

	status_t                  res_status;
	logic [NEW_SLOT_W-1:0]    res_new;
	logic                     res_allowed;
	logic                     wr_en;
	logic [SLOT_W-1:0]        wr_addr;
	crt_entry_t               wr_entry;
	logic                     inc_count;
	logic                     clr_valid;

	// capture the request
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q   <= command;
			index_q <= slot_index;
			obj_q   <= object_ref;
			mask_q  <= rights_mask;
			badge_q <= badge_value;
		end
	end

	// read address: the addressed slot at lookup, then slots in order while scanning
	assign scan_left = (scan_idx_q < count_q);
	assign rd_en     = ctl.lookup || (ctl.scan && scan_left);
	assign rd_addr   = ctl.lookup ? SLOT_W'(index_q) : scan_idx_q[SLOT_W-1:0];

	// slot memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_mem[wr_addr] <= wr_entry;
		end
		if (rd_en) begin
			rd_entry_s1 <= slot_mem[rd_addr];
			rd_valid_s1 <= slot_valid_q[rd_addr];
		end
	end

	// scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q <= '0;
			issued_s1  <= 1'b0;
			hit_q      <= 1'b0;
		end else if (ctl.lookup) begin
			scan_idx_q <= '0;
			issued_s1  <= 1'b0;
			hit_q      <= 1'b0;
		end else if (ctl.scan) begin
			issued_s1 <= scan_left;
			if (scan_left) begin
				scan_idx_q <= scan_idx_q + 1'b1;
			end
			if (issued_s1 && rd_valid_s1 && (|(rd_entry_s1.rights & mask_q))) begin
				hit_q <= 1'b1;
			end
		end
	end

	assign out_room       = !out_valid_q || out_ready;
	assign stat.out_room  = out_room;
	assign stat.scan_done = !scan_left && !issued_s1;
	assign stat.need_scan = (cmd_q == CMD_CHECK_ANY) && (count_q != '0) && (mask_q != '0);

	assign in_range = (CMP_W'(index_q) < CMP_W'(count_q));
	assign full     = (count_q == COUNT_W'(CAP_SLOTS));

	// command execution
	always_comb begin
		res_status  = ST_OK;
		res_new     = '0;
		res_allowed = 1'b0;
		wr_en       = 1'b0;
		wr_addr     = count_q[SLOT_W-1:0];
		wr_entry    = rd_entry_s1;
		inc_count   = 1'b0;
		clr_valid   = 1'b0;
		unique case (cmd_q)
			CMD_CREATE: begin
				if (full) begin
					res_status = ST_FULL;
				end else begin
					wr_en           = 1'b1;
					inc_count       = 1'b1;
					res_new         = NEW_SLOT_W'(count_q);
					wr_entry.object_ref = obj_q;
					wr_entry.badge      = badge_q;
					wr_entry.rights     = mask_q & RIGHTS_ALL;
				end
			end
			CMD_GRANT: begin
				if (!in_range) begin
					res_status = ST_BAD_INDEX;
				end else if (!rd_valid_s1) begin
					res_status = ST_INVALID;
				end else if ((rd_entry_s1.rights & RIGHT_GRANT) == '0) begin
					res_status = ST_NO_GRANT;
				end else if (full) begin
					res_status = ST_FULL;
				end else begin
					wr_en           = 1'b1;
					inc_count       = 1'b1;
					res_new         = NEW_SLOT_W'(count_q);
					wr_entry.rights = rd_entry_s1.rights & mask_q;
				end
			end
			CMD_REVOKE: begin
				if (!in_range) begin
					res_status = ST_BAD_INDEX;
				end else begin
					// object is kept, rights and badge cleared
					wr_en           = 1'b1;
					wr_addr         = SLOT_W'(index_q);
					wr_entry.badge  = '0;
					wr_entry.rights = '0;
					clr_valid       = 1'b1;
				end
			end
			CMD_CHECK: begin
				if (!in_range) begin
					res_status = ST_BAD_INDEX;
				end else if (!rd_valid_s1) begin
					res_status = ST_INVALID;
				end else begin
					res_allowed = |(rd_entry_s1.rights & mask_q);
				end
			end
			CMD_CHECK_ANY: begin
				// empty table or empty mask passes
				res_allowed = (count_q == '0) || (mask_q == '0) || hit_q;
			end
			default: begin
				res_status = ST_OK;
			end
		endcase
		if (!ctl.commit) begin
			wr_en     = 1'b0;
			inc_count = 1'b0;
			clr_valid = 1'b0;
		end
	end

	// valid bits and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
			count_q      <= '0;
		end else begin
			if (inc_count) begin
				slot_valid_q[count_q[SLOT_W-1:0]] <= 1'b1;
				count_q <= count_q + 1'b1;
			end
			if (clr_valid) begin
				slot_valid_q[SLOT_W'(index_q)] <= 1'b0;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.commit) begin
			out_status_q  <= res_status;
			out_new_q     <= res_new;
			out_allowed_q <= res_allowed;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = out_status_q;
	assign new_slot  = out_new_q;
	assign allowed   = out_allowed_q;

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_W'(CAP_SLOTS))
		else $error("slot count beyond table size");

	a_commit_room: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.commit |-> out_room)
		else $error("result committed over a pending result");

	a_append_count: assert property (@(posedge clk) disable iff (!arst_n)
		inc_count |=> count_q == COUNT_W'($past(count_q) + 1'b1))
		else $error("append did not advance the slot count");

	a_hit_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(hit_q) |-> $past(ctl.scan))
		else $error("scan hit set outside a scan");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		scan_idx_q <= count_q)
		else $error("scan index past the used slots");

endmodule

[rtl/core/capability_rights_table.sv]
// ----------------------------------------------------------------------------
// capability_rights_table
// Append-only capability table with create, grant, revoke, check and
// check-any commands.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one request: command, slot_index,
//   object_ref, rights_mask, badge_value. Output channel (out_valid/out_ready)
//   returns one result per request: status, new_slot, allowed.
//   in_ready is high only while the sequencer is idle; one request is in
//   work at a time.
//   A request goes through a lookup step for the registered slot memory read,
//   then an execute step.
//   Check-any with a non-empty table and a non-zero mask reads the used slots
//   one per cycle through the same memory port in a scan step before execute.
//   Results sit in an output register, so a new request is accepted while a
//   result still waits; a stalled receiver holds only the execute step.
//   Reset clears the slot count, all valid bits and the output valid; slot
//   memory contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module capability_rights_table (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic [crt_pkg::CMD_W-1:0]               command,
	input  logic [crt_pkg::INDEX_W-1:0]             slot_index,
	input  logic signed [crt_pkg::DATA_W-1:0]       object_ref,
	input  logic [crt_pkg::RIGHTS_W-1:0]            rights_mask,
	input  logic signed [crt_pkg::DATA_W-1:0]       badge_value,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic [crt_pkg::STATUS_W-1:0]            status,
	output logic [crt_pkg::NEW_SLOT_W-1:0]          new_slot,
	output logic                                    allowed
);
	import crt_pkg::*;

	crt_ctl_t  ctl;
	crt_stat_t stat;

	// sequencer
	crt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.ctl      (ctl)
	);

	// table and result path
	crt_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.stat        (stat),
		.command     (command),
		.slot_index  (slot_index),
		.object_ref  (object_ref),
		.rights_mask (rights_mask),
		.badge_value (badge_value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.new_slot    (new_slot),
		.allowed     (allowed)
	);

endmodule

[tb/capability_rights_table_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// capability_rights_table_tb
// Self-checking bench for the capability rights table. A scoreboard keeps a
// shadow copy of the slot table, predicts one reply per accepted request and
// compares every reply field by field. Requests come in bursts with random
// gaps, the reply side stalls on its own pattern, and the run includes a long
// reply-side hold-off and a full drain in the middle.
// ----------------------------------------------------------------------------
module capability_rights_table_tb;
	import crt_pkg::*;

	localparam int LIMIT_CYCLES  = 400_000;
	localparam int RANDOM_ITEMS  = 430;
	localparam int DRAIN_AT      = 150;
	localparam int HOLD_AT       = 260;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = CAP_SLOTS + 16;
	localparam int INDEX_MAX     = (1 << INDEX_W) - 1;

	// command codes the block ignores
	localparam logic [CMD_W-1:0] CMD_FIRST_UNUSED = 3'd5;
	localparam logic [CMD_W-1:0] CMD_MID_UNUSED   = 3'd6;
	localparam logic [CMD_W-1:0] CMD_LAST_CODE    = 3'd7;

	typedef struct {
		status_t                 status;
		logic [NEW_SLOT_W-1:0]   new_slot;
		logic                    allowed;
	} cap_reply_t;

	// Shadow slot table plus the queue of replies still owed by the block.
	class cap_rights_board;
		bit                       slot_live[CAP_SLOTS];
		logic [RIGHTS_W-1:0]      slot_rights[CAP_SLOTS];
		logic signed [DATA_W-1:0] slot_object[CAP_SLOTS];
		logic signed [DATA_W-1:0] slot_badge[CAP_SLOTS];
		int unsigned              used;
		cap_reply_t               owed_replies[$];
		int                       errors;
		int                       replies_checked;
		int                       full_replies;

		function new();
			used = 0;
			errors = 0;
			replies_checked = 0;
			full_replies = 0;
			foreach (slot_live[i]) begin
				slot_live[i] = 1'b0;
				slot_rights[i] = '0;
				slot_object[i] = '0;
				slot_badge[i] = '0;
			end
		endfunction

		function int unsigned used_slots();
			return used;
		endfunction

		function int pending();
			return owed_replies.size();
		endfunction

		// append one slot, or report the table full
		function void append_slot(logic signed [DATA_W-1:0] obj, logic [RIGHTS_W-1:0] rights,
				logic signed [DATA_W-1:0] badge, inout cap_reply_t reply);
			if (used >= CAP_SLOTS) begin
				reply.status = ST_FULL;
				full_replies++;
			end else begin
				slot_object[used] = obj;
				slot_rights[used] = rights & RIGHTS_ALL;
				slot_badge[used] = badge;
				slot_live[used] = 1'b1;
				reply.new_slot = used[NEW_SLOT_W-1:0];
				used++;
			end
		endfunction

		// update the shadow table for one accepted request and queue its reply
		function void note_request(logic [CMD_W-1:0] cmd, logic [INDEX_W-1:0] idx,
				logic signed [DATA_W-1:0] obj, logic [RIGHTS_W-1:0] mask,
				logic signed [DATA_W-1:0] badge);
			cap_reply_t reply;
			bit         in_range;
			reply.status = ST_OK;
			reply.new_slot = '0;
			reply.allowed = 1'b0;
			in_range = (idx < used) && (idx < CAP_SLOTS);
			case (cmd)
				CMD_CREATE: append_slot(obj, mask, badge, reply);
				CMD_GRANT: begin
					if (!in_range)
						reply.status = ST_BAD_INDEX;
					else if (!slot_live[idx])
						reply.status = ST_INVALID;
					else if ((slot_rights[idx] & RIGHT_GRANT) == '0)
						reply.status = ST_NO_GRANT;
					else
						append_slot(slot_object[idx], slot_rights[idx] & mask,
							slot_badge[idx], reply);
				end
				CMD_REVOKE: begin
					if (!in_range) begin
						reply.status = ST_BAD_INDEX;
					end else begin
						slot_rights[idx] = '0;
						slot_badge[idx] = '0;
						slot_live[idx] = 1'b0;
					end
				end
				CMD_CHECK: begin
					if (!in_range)
						reply.status = ST_BAD_INDEX;
					else if (!slot_live[idx])
						reply.status = ST_INVALID;
					else
						reply.allowed = (slot_rights[idx] & mask) != '0;
				end
				CMD_CHECK_ANY: begin
					if (used == 0 || mask == '0) begin
						reply.allowed = 1'b1;
					end else begin
						for (int i = 0; i < used && i < CAP_SLOTS; i++)
							if (slot_live[i] && (slot_rights[i] & mask) != '0)
								reply.allowed = 1'b1;
					end
				end
				default: ;
			endcase
			owed_replies.push_back(reply);
		endfunction

		// compare one reply with the oldest one owed
		function void check_result(logic [STATUS_W-1:0] status,
				logic [NEW_SLOT_W-1:0] new_slot, logic allowed);
			cap_reply_t want;
			if (owed_replies.size() == 0) begin
				$display("%0t: unexpected reply status %0d new_slot %0d allowed %0d",
					$time, status, new_slot, allowed);
				errors++;
				return;
			end
			want = owed_replies.pop_front();
			replies_checked++;
			if (status !== want.status) begin
				$display("%0t: status expected %0d got %0d", $time, want.status, status);
				errors++;
			end
			if (new_slot !== want.new_slot) begin
				$display("%0t: new_slot expected %0d got %0d", $time, want.new_slot,
					new_slot);
				errors++;
			end
			if (allowed !== want.allowed) begin
				$display("%0t: allowed expected %0d got %0d", $time, want.allowed, allowed);
				errors++;
			end
		endfunction
	endclass

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_ready;
	logic [CMD_W-1:0]           command;
	logic [INDEX_W-1:0]         slot_index;
	logic signed [DATA_W-1:0]   object_ref;
	logic [RIGHTS_W-1:0]        rights_mask;
	logic signed [DATA_W-1:0]   badge_value;
	logic                       out_valid;
	logic                       out_ready;
	logic [STATUS_W-1:0]        status;
	logic [NEW_SLOT_W-1:0]      new_slot;
	logic                       allowed;

	cap_rights_board rights_board = new();
	int              cycle_count = 0;
	int              requests_sent = 0;
	bit              hold_request = 1'b0;

	capability_rights_table DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.command     (command),
		.slot_index  (slot_index),
		.object_ref  (object_ref),
		.rights_mask (rights_mask),
		.badge_value (badge_value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.new_slot    (new_slot),
		.allowed     (allowed)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// offer one request and hold it until accepted; called at a rising edge
	task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [INDEX_W-1:0] idx,
			input logic signed [DATA_W-1:0] obj, input logic [RIGHTS_W-1:0] mask,
			input logic signed [DATA_W-1:0] badge);
		command <= cmd;
		slot_index <= idx;
		object_ref <= obj;
		rights_mask <= mask;
		badge_value <= badge;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		rights_board.note_request(cmd, idx, obj, mask, badge);
		requests_sent++;
	endtask

	// random request, weighted toward in-range slots and lookups
	task automatic send_random_request();
		logic [CMD_W-1:0]    cmd;
		logic [INDEX_W-1:0]  idx;
		int                  pick;
		int unsigned         used;
		pick = $urandom_range(0, 99);
		used = rights_board.used_slots();
		if (pick < 12)
			cmd = CMD_CREATE;
		else if (pick < 30)
			cmd = CMD_GRANT;
		else if (pick < 38)
			cmd = CMD_REVOKE;
		else if (pick < 66)
			cmd = CMD_CHECK;
		else if (pick < 92)
			cmd = CMD_CHECK_ANY;
		else
			cmd = CMD_W'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_CODE));
		pick = $urandom_range(0, 99);
		if (used == 0 || pick < 8)
			idx = INDEX_W'($urandom_range(0, INDEX_MAX));
		else if (pick < 14)
			idx = INDEX_W'(used);
		else
			idx = INDEX_W'($urandom_range(0, used - 1));
		send_request(cmd, idx, $urandom, RIGHTS_W'($urandom_range(0, RIGHTS_ALL)), $urandom);
	endtask

	// drop valid for a number of cycles
	task automatic idle_gap(input int cycles);
		if (cycles > 0) begin
			in_valid <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	// reply side: random stall modes plus one long hold-off
	initial begin
		int mode;
		int mode_left;
		int hold_left;
		bit held;
		mode = 0;
		mode_left = 0;
		hold_left = 0;
		held = 1'b0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				rights_board.check_result(status, new_slot, allowed);
			if (hold_request && !held) begin
				held = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (mode_left == 0) begin
				mode = $urandom_range(0, 2);
				mode_left = $urandom_range(20, 80);
			end
			mode_left--;
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					default: out_ready <= ($urandom_range(0, 4) == 0);
				endcase
			end
		end
	end

	// request side
	initial begin
		int issued;
		int burst;
		bit drained;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		command <= CMD_CREATE;
		slot_index <= '0;
		object_ref <= '0;
		rights_mask <= '0;
		badge_value <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table: scan allows, indexed commands see a bad index
		send_request(CMD_CHECK_ANY, 8'd0, 32'sd0, 3'd7, 32'sd0);
		send_request(CMD_CHECK, 8'd0, 32'sd0, 3'd7, 32'sd0);
		send_request(CMD_REVOKE, 8'd0, 32'sd0, 3'd0, 32'sd0);
		send_request(CMD_GRANT, 8'd0, 32'sd0, 3'd7, 32'sd0);
		// creates with extreme object references and badges
		send_request(CMD_CREATE, 8'd0, 32'sh8000_0000, 3'd7, 32'sh7fff_ffff);
		idle_gap(3);
		send_request(CMD_CREATE, 8'hff, 32'sh7fff_ffff, 3'd0, 32'sh8000_0000);
		send_request(CMD_CREATE, 8'd0, -32'sd1, 3'd3, 32'sd0);
		send_request(CMD_CHECK_ANY, 8'd0, 32'sd0, 3'd0, 32'sd0);
		send_request(CMD_CHECK, 8'd0, 32'sd0, 3'd4, 32'sd0);
		send_request(CMD_CHECK, 8'd1, 32'sd0, 3'd7, 32'sd0);
		// empty mask on a slot check
		send_request(CMD_CHECK, 8'd0, 32'sd0, 3'd0, 32'sd0);
		// grant from a slot without the grant right, then a narrowing grant
		send_request(CMD_GRANT, 8'd2, 32'sd0, 3'd7, 32'sd0);
		send_request(CMD_GRANT, 8'd0, 32'sd0, 3'd5, 32'sd0);
		send_request(CMD_GRANT, 8'd1, 32'sd0, 3'd7, 32'sd0);
		// revoke twice, then use the dead slot
		send_request(CMD_REVOKE, 8'd0, 32'sd0, 3'd0, 32'sd0);
		send_request(CMD_REVOKE, 8'd0, 32'sd0, 3'd0, 32'sd0);
		send_request(CMD_CHECK, 8'd0, 32'sd0, 3'd1, 32'sd0);
		send_request(CMD_GRANT, 8'd0, 32'sd0, 3'd7, 32'sd0);
		// scan that finds no holder of the write right
		send_request(CMD_REVOKE, 8'd2, 32'sd0, 3'd0, 32'sd0);
		send_request(CMD_CHECK_ANY, 8'd0, 32'sd0, 3'd2, 32'sd0);
		// indexes at and far past the end
		send_request(CMD_CHECK, 8'd4, 32'sd0, 3'd7, 32'sd0);
		send_request(CMD_CHECK, 8'hff, 32'sd0, 3'd7, 32'sd0);
		// ignored command codes
		send_request(CMD_FIRST_UNUSED, 8'd1, 32'sd5, 3'd7, 32'sd5);
		send_request(CMD_MID_UNUSED, 8'd0, 32'sd0, 3'd0, 32'sd0);
		send_request(CMD_LAST_CODE, 8'hff, -32'sd1, 3'd7, -32'sd1);

		// random bursts
		issued = 0;
		drained = 1'b0;
		while (issued < RANDOM_ITEMS) begin
			if (issued >= HOLD_AT && !hold_request) begin
				hold_request = 1'b1;
				burst = 24;
			end else begin
				burst = $urandom_range(1, 16);
			end
			for (int k = 0; k < burst && issued < RANDOM_ITEMS; k++) begin
				send_random_request();
				issued++;
			end
			if (issued >= DRAIN_AT && !drained) begin
				drained = 1'b1;
				in_valid <= 1'b0;
				do @(posedge clk); while (rights_board.pending() != 0);
			end else if ($urandom_range(0, 3) != 0) begin
				idle_gap($urandom_range(1, 12));
			end
		end
		in_valid <= 1'b0;

		// wait out the last replies, then allow for a stray one
		while (rights_board.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Sent %0d requests, checked %0d replies; %0d of %0d slots used, %0d full replies",
			requests_sent, rights_board.replies_checked, rights_board.used_slots(),
			CAP_SLOTS, rights_board.full_replies);
		if (rights_board.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

[sim.f]
rtl/core/crt_pkg.sv
rtl/core/crt_ctrl.sv
rtl/core/crt_dp.sv
rtl/core/capability_rights_table.sv
tb/capability_rights_table_tb.sv
